### design/assert_macros.svh
// Assertion macros for the checker file of the vector direction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VDA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vda assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vda assertion failed");

`endif

### design/vda_pkg.sv
// Package with widths, types, constants and helper functions of the vector direction block.
package vda_pkg;

    // Field and datapath widths.
    localparam int COORD_WIDTH   = 24;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int DATA_WIDTH    = 64;
    localparam int PHASE_WIDTH   = 32;
    localparam int GUARD_SHIFT   = 60 - COORD_WIDTH;

    // Gain compensation: multiply by INV_GAIN / 2^GAIN_FRAC_BITS.
    localparam int GAIN_FRAC_BITS = 31;
    localparam int GAIN_HI_WIDTH  = DATA_WIDTH - GAIN_FRAC_BITS;
    localparam logic [GAIN_FRAC_BITS-1:0] INV_GAIN = 31'd1304065748;

    // Pre-rotation angles of plus and minus a quarter turn.
    localparam logic [PHASE_WIDTH-1:0] PHASE_QUARTER     = 32'h4000_0000;
    localparam logic [PHASE_WIDTH-1:0] PHASE_NEG_QUARTER = 32'hC000_0000;

    // Output rounding of the phase to the angle width.
    localparam int ROUND_SHIFT = PHASE_WIDTH - ANGLE_WIDTH;
    localparam logic [PHASE_WIDTH-1:0] ROUND_HALF = (32'd1 << ROUND_SHIFT) >> 1;

    // Register stages from input to output, used by the checker.
    localparam int PIPE_DEPTH = 2 * CORDIC_STAGES + 5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
    typedef logic signed [DATA_WIDTH-1:0]  data_t;
    typedef logic        [PHASE_WIDTH-1:0] phase_t;

    // Input transaction payload.
    typedef struct packed {
        coord_t x_coord;
        coord_t y_coord;
        coord_t z_coord;
    } in_t;

    // Output transaction payload.
    typedef struct packed {
        angle_t first_angle;
        angle_t second_angle;
    } out_t;

    // Vector state carried through a CORDIC pipeline.
    typedef struct packed {
        data_t  x;
        data_t  y;
        phase_t ang;
        logic   zero;
    } vec_t;

    // Side data that travels with each transaction.
    typedef struct packed {
        logic   three_dim;
        coord_t y_coord;
        phase_t theta;
    } side_t;

    // Arctangent table, round(atan(2^-i) * 2^31 / pi).
    function automatic phase_t atan_entry(input int unsigned idx);
        phase_t val;
        case (idx)
            0:  val = 32'h20000000;
            1:  val = 32'h12E4051E;
            2:  val = 32'h09FB385B;
            3:  val = 32'h051111D4;
            4:  val = 32'h028B0D43;
            5:  val = 32'h0145D7E1;
            6:  val = 32'h00A2F61E;
            7:  val = 32'h00517C55;
            8:  val = 32'h0028BE53;
            9:  val = 32'h00145F2F;
            10: val = 32'h000A2F98;
            11: val = 32'h000517CC;
            12: val = 32'h00028BE6;
            13: val = 32'h000145F3;
            14: val = 32'h0000A2FA;
            15: val = 32'h0000517D;
            16: val = 32'h000028BE;
            17: val = 32'h0000145F;
            18: val = 32'h00000A30;
            19: val = 32'h00000518;
            20: val = 32'h0000028C;
            21: val = 32'h00000146;
            22: val = 32'h000000A3;
            23: val = 32'h00000051;
            24: val = 32'h00000029;
            25: val = 32'h00000014;
            26: val = 32'h0000000A;
            27: val = 32'h00000005;
            28: val = 32'h00000003;
            29: val = 32'h00000001;
            30: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

    // Sign-extend a coordinate into the datapath and scale it up.
    function automatic data_t scale_coord(input coord_t c);
        data_t ext;
        ext = data_t'(c);
        return ext <<< GUARD_SHIFT;
    endfunction

    // Round a phase half up to the angle width; the result wraps.
    function automatic angle_t to_angle(input phase_t a);
        phase_t sum;
        sum = a + ROUND_HALF;
        return angle_t'(sum[PHASE_WIDTH-1 -: ANGLE_WIDTH]);
    endfunction

endpackage

### design/vector_direction_angles.sv
// Path: pre-rotation, CORDIC, gain, pre-rotation, CORDIC, output register. Without
// output stall one transaction per cycle; each of the two 16-stage unrolled CORDIC
// pipelines and the two-stage gain multiplier takes a new vector every cycle.
// A stall at the output holds only the stages that are full; bubbles still fill.
// Reset clears every valid bit and sets three_dim to 1 (3D heading and elevation).
module vector_direction_angles (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  vda_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output vda_pkg::out_t out_data
);

    logic           three_dim_reg;
    logic           three_dim_next;

    vda_pkg::data_t p1_y;
    vda_pkg::side_t p1_in_side;
    logic           p1_valid;
    logic           p1_stall;
    vda_pkg::vec_t  p1_vec;
    vda_pkg::side_t p1_side;

    logic           c1_valid;
    logic           c1_stall;
    vda_pkg::vec_t  c1_vec;
    vda_pkg::side_t c1_side;
    vda_pkg::side_t g_in_side;

    logic           g_valid;
    logic           g_stall;
    vda_pkg::data_t g_mag;
    vda_pkg::side_t g_side;

    logic           p2_valid;
    logic           p2_stall;
    vda_pkg::vec_t  p2_vec;
    vda_pkg::side_t p2_side;

    logic           c2_valid;
    vda_pkg::vec_t  c2_vec;
    vda_pkg::side_t c2_side;

    logic           out_valid_reg;
    logic           out_valid_next;
    vda_pkg::out_t  out_data_reg;
    vda_pkg::out_t  out_data_next;
    logic           out_load;

    // Mode register.
    assign three_dim_next = cfg_wr_en ? cfg_wr_data : three_dim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_dim_reg <= 1'b1;
        end
        else
        begin
            three_dim_reg <= three_dim_next;
        end
    end

    // First pass works on (x, z) in 3D mode and on (x, y) in planar mode.
    assign p1_y = three_dim_reg ? vda_pkg::scale_coord(in_data.z_coord)
                                : vda_pkg::scale_coord(in_data.y_coord);

    always_comb
    begin
        p1_in_side.three_dim = three_dim_reg;
        p1_in_side.y_coord   = in_data.y_coord;
        p1_in_side.theta     = '0;
    end

    vda_prerot u_prerot1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_x      (vda_pkg::scale_coord(in_data.x_coord)),
        .in_y      (p1_y),
        .in_side   (p1_in_side),
        .out_valid (p1_valid),
        .out_stall (p1_stall),
        .out_vec   (p1_vec),
        .out_side  (p1_side)
    );

    vda_cordic u_cordic1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_valid),
        .in_stall  (p1_stall),
        .in_vec    (p1_vec),
        .in_side   (p1_side),
        .out_valid (c1_valid),
        .out_stall (c1_stall),
        .out_vec   (c1_vec),
        .out_side  (c1_side)
    );

    // The first angle rides along as theta from here on.
    always_comb
    begin
        g_in_side       = c1_side;
        g_in_side.theta = c1_vec.ang;
    end

    vda_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid),
        .in_stall  (c1_stall),
        .in_mag    (c1_vec.x),
        .in_side   (g_in_side),
        .out_valid (g_valid),
        .out_stall (g_stall),
        .out_mag   (g_mag),
        .out_side  (g_side)
    );

    // Second pass works on (compensated magnitude, y).
    vda_prerot u_prerot2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .in_stall  (g_stall),
        .in_x      (g_mag),
        .in_y      (vda_pkg::scale_coord(g_side.y_coord)),
        .in_side   (g_side),
        .out_valid (p2_valid),
        .out_stall (p2_stall),
        .out_vec   (p2_vec),
        .out_side  (p2_side)
    );

    vda_cordic u_cordic2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid),
        .in_stall  (p2_stall),
        .in_vec    (p2_vec),
        .in_side   (p2_side),
        .out_valid (c2_valid),
        .out_stall (out_valid_reg && out_stall),
        .out_vec   (c2_vec),
        .out_side  (c2_side)
    );

    // Output stage: select and round the angles.
    assign out_load = !(out_valid_reg && out_stall);

    always_comb
    begin
        if (c2_side.three_dim)
        begin
            out_data_next.first_angle  = vda_pkg::to_angle(c2_vec.ang);
            out_data_next.second_angle = vda_pkg::to_angle('0 - c2_side.theta);
        end
        else
        begin
            out_data_next.first_angle  = vda_pkg::to_angle(c2_side.theta);
            out_data_next.second_angle = '0;
        end
    end

    assign out_valid_next = out_load ? c2_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/vda_prerot.sv
// Pipeline stage that detects a zero vector and turns the vector into the right half plane.
module vda_prerot (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  vda_pkg::data_t  in_x,
    input  vda_pkg::data_t  in_y,
    input  vda_pkg::side_t  in_side,
    output logic            out_valid,
    input  logic            out_stall,
    output vda_pkg::vec_t   out_vec,
    output vda_pkg::side_t  out_side
);

    logic           valid_reg;
    logic           valid_next;
    vda_pkg::vec_t  vec_reg;
    vda_pkg::vec_t  vec_next;
    vda_pkg::side_t side_reg;
    logic           load;

    // The stage holds while it has a transaction that the next stage refuses.
    assign in_stall = valid_reg && out_stall;
    assign load     = !in_stall;

    // Pre-rotation by a quarter turn for a vector in the left half plane.
    always_comb
    begin
        vec_next.x    = in_x;
        vec_next.y    = in_y;
        vec_next.ang  = '0;
        vec_next.zero = (in_x == '0) && (in_y == '0);
        if (in_x[vda_pkg::DATA_WIDTH-1])
        begin
            if (!in_y[vda_pkg::DATA_WIDTH-1])
            begin
                vec_next.x   = in_y;
                vec_next.y   = -in_x;
                vec_next.ang = vda_pkg::PHASE_QUARTER;
            end
            else
            begin
                vec_next.x   = -in_y;
                vec_next.y   = in_x;
                vec_next.ang = vda_pkg::PHASE_NEG_QUARTER;
            end
        end
    end

    assign valid_next = load ? in_valid : valid_reg;

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

### design/vda_cordic.sv
// Unrolled CORDIC vectoring pipeline, one micro-rotation per register stage.
module vda_cordic (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  vda_pkg::vec_t   in_vec,
    input  vda_pkg::side_t  in_side,
    output logic            out_valid,
    input  logic            out_stall,
    output vda_pkg::vec_t   out_vec,
    output vda_pkg::side_t  out_side
);

    localparam int NS = vda_pkg::CORDIC_STAGES;

    logic           valid_reg  [NS];
    logic           valid_next [NS];
    vda_pkg::vec_t  vec_reg    [NS];
    vda_pkg::vec_t  vec_next   [NS];
    vda_pkg::side_t side_reg   [NS];
    logic           src_valid  [NS];
    vda_pkg::vec_t  src_vec    [NS];
    vda_pkg::side_t src_side   [NS];
    logic           stage_stall[NS];
    logic           down_stall [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        vda_pkg::data_t xs;
        vda_pkg::data_t ys;
        logic           load;

        // Source of this stage: the module input or the stage before.
        if (k == 0)
        begin : g_first
            assign src_valid[k] = in_valid;
            assign src_vec[k]   = in_vec;
            assign src_side[k]  = in_side;
        end
        else
        begin : g_chain
            assign src_valid[k] = valid_reg[k-1];
            assign src_vec[k]   = vec_reg[k-1];
            assign src_side[k]  = side_reg[k-1];
        end

        // Stall seen from the stage after this one.
        if (k == NS - 1)
        begin : g_last
            assign down_stall[k] = out_stall;
        end
        else
        begin : g_mid
            assign down_stall[k] = stage_stall[k+1];
        end

        assign stage_stall[k] = valid_reg[k] && down_stall[k];
        assign load           = !stage_stall[k];

        // One micro-rotation that drives y toward zero.
        always_comb
        begin
            xs = $signed(src_vec[k].x) >>> k;
            ys = $signed(src_vec[k].y) >>> k;
            vec_next[k] = src_vec[k];
            if (!src_vec[k].zero)
            begin
                if (!src_vec[k].y[vda_pkg::DATA_WIDTH-1])
                begin
                    vec_next[k].x   = src_vec[k].x + ys;
                    vec_next[k].y   = src_vec[k].y - xs;
                    vec_next[k].ang = src_vec[k].ang + vda_pkg::atan_entry(k);
                end
                else
                begin
                    vec_next[k].x   = src_vec[k].x - ys;
                    vec_next[k].y   = src_vec[k].y + xs;
                    vec_next[k].ang = src_vec[k].ang - vda_pkg::atan_entry(k);
                end
            end
        end

        assign valid_next[k] = load ? src_valid[k] : valid_reg[k];

        // Valid bit of the stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_next[k];
            end
        end

        // Payload of the stage.
        always_ff @(posedge clk)
        begin
            if (load)
            begin
                vec_reg[k]  <= vec_next[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign in_stall  = stage_stall[0];
    assign out_valid = valid_reg[NS-1];
    assign out_vec   = vec_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

### design/vda_gain.sv
// Two-stage multiplier that removes the CORDIC gain from the magnitude.
module vda_gain (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  vda_pkg::data_t  in_mag,
    input  vda_pkg::side_t  in_side,
    output logic            out_valid,
    input  logic            out_stall,
    output vda_pkg::data_t  out_mag,
    output vda_pkg::side_t  out_side
);

    localparam int F  = vda_pkg::GAIN_FRAC_BITS;
    localparam int HW = vda_pkg::GAIN_HI_WIDTH;
    localparam int DW = vda_pkg::DATA_WIDTH;

    logic               valid_a_reg;
    logic               valid_a_next;
    logic [2*F-1:0]     lo_prod_a_reg;
    logic [2*F-1:0]     lo_prod_a_next;
    logic [HW-1:0]      hi_a_reg;
    logic               pos_a_reg;
    logic               pos_a_next;
    vda_pkg::side_t     side_a_reg;
    logic               stall_a;
    logic               load_a;

    logic               valid_b_reg;
    logic               valid_b_next;
    vda_pkg::data_t     mag_b_reg;
    vda_pkg::data_t     mag_b_next;
    vda_pkg::side_t     side_b_reg;
    logic               stall_b;
    logic               load_b;
    logic [DW-1:0]      hi_prod;

    // The constant widened to the low product width.
    function automatic logic [2*F-1:0] INV_GAIN_EXT();
        return {{F{1'b0}}, vda_pkg::INV_GAIN};
    endfunction

    // Stall chain through the two stages.
    assign stall_b  = valid_b_reg && out_stall;
    assign stall_a  = valid_a_reg && stall_b;
    assign load_b   = !stall_b;
    assign load_a   = !stall_a;
    assign in_stall = stall_a;

    // First stage: low half of the magnitude times the constant.
    assign lo_prod_a_next = in_mag[F-1:0] * INV_GAIN_EXT();
    assign pos_a_next     = !in_mag[DW-1] && (in_mag != '0);
    assign valid_a_next   = load_a ? in_valid : valid_a_reg;

    // Second stage: high half times the constant plus the carried low product.
    assign hi_prod    = hi_a_reg * {{(DW-F){1'b0}}, vda_pkg::INV_GAIN};
    assign mag_b_next = pos_a_reg
                      ? vda_pkg::data_t'(hi_prod + DW'(lo_prod_a_reg[2*F-1:F]))
                      : '0;
    assign valid_b_next = load_b ? valid_a_reg : valid_b_reg;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= valid_a_next;
            valid_b_reg <= valid_b_next;
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            lo_prod_a_reg <= lo_prod_a_next;
            hi_a_reg      <= in_mag[DW-1:F];
            pos_a_reg     <= pos_a_next;
            side_a_reg    <= in_side;
        end
        if (load_b)
        begin
            mag_b_reg  <= mag_b_next;
            side_b_reg <= side_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_mag   = mag_b_reg;
    assign out_side  = side_b_reg;

endmodule

### design/vda_checker.sv
// Port-level checker for the vector direction block and its bind statement.
`include "assert_macros.svh"

module vda_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          in_valid,
    input  logic          in_stall,
    input  vda_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_stall,
    input  vda_pkg::out_t out_data
);

    localparam int CNT_W = $clog2(vda_pkg::PIPE_DEPTH + 2);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             in_fire;
    logic             out_fire;

    // Number of transactions inside the pipeline.
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_fire && !out_fire)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (out_fire && !in_fire)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // A stalled output transaction stays and keeps its payload.
    `VDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `VDA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
    // The input is stalled only when the output is.
    `VDA_ASSERT_IMPL(a_stall_origin, !out_stall, !in_stall)
    // The pipeline never holds more transactions than it has stages.
    `VDA_ASSERT_IMPL(a_fill_limit, 1'b1, cnt_reg <= CNT_W'(vda_pkg::PIPE_DEPTH))
    // No output transaction appears from an empty pipeline.
    `VDA_ASSERT_IMPL(a_no_phantom, cnt_reg == '0, !out_valid)

endmodule

bind vector_direction_angles vda_checker u_vda_checker (.*);

### bench/direction_checker.sv
// Checker that predicts the direction angles of each accepted vector and compares the results.
`timescale 1ns / 100ps

module direction_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          in_valid,
    input  logic          in_stall,
    input  vda_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_stall,
    input  vda_pkg::out_t out_data,
    output int            angles_due,
    output int            fault_count
);

    // Coordinates are moved up into a 64-bit datapath with this many guard bits.
    localparam int SCALE_SHIFT = 60 - vda_pkg::COORD_WIDTH;
    // Limit of 1/K for the CORDIC gain, as a fraction of 2^31.
    localparam longint unsigned RECIP_GAIN = 64'd1304065748;
    localparam bit [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam bit [31:0] HALF_LSB = 32'd1 << (32 - vda_pkg::ANGLE_WIDTH - 1);

    // Each expected transaction keeps its input vector for the mismatch report.
    typedef struct packed {
        vda_pkg::in_t  vec;
        vda_pkg::out_t angles;
    } predicted_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    bit [31:0] arctan_lut [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    predicted_t angle_q[$];
    predicted_t head;
    logic       spatial_mode;
    int         faults;
    int         reported;

    assign fault_count = faults;

    // CORDIC vectoring: binary angle of (ax, ay) and the gain-scaled radius.
    function automatic bit [31:0] vector_phase(input longint ax, input longint ay,
                                               output longint radius);
        longint    px;
        longint    py;
        longint    sx;
        longint    sy;
        longint    swap;
        bit [31:0] phase;
        px    = ax;
        py    = ay;
        phase = '0;
        if (px == 0 && py == 0)
        begin
            radius = 0;
        end
        else
        begin
            // A left-half-plane vector is first turned by a quarter turn.
            if (px < 0)
            begin
                swap = px;
                if (py >= 0)
                begin
                    px    = py;
                    py    = -swap;
                    phase = QUARTER_TURN;
                end
                else
                begin
                    px    = -py;
                    py    = swap;
                    phase = 32'd0 - QUARTER_TURN;
                end
            end
            for (int i = 0; i < vda_pkg::CORDIC_STAGES && i < 32; i++)
            begin
                sx = px >>> i;
                sy = py >>> i;
                if (py >= 0)
                begin
                    px    = px + sy;
                    py    = py - sx;
                    phase = phase + arctan_lut[i];
                end
                else
                begin
                    px    = px - sy;
                    py    = py + sx;
                    phase = phase - arctan_lut[i];
                end
            end
            radius = px;
        end
        return phase;
    endfunction

    // Remove the CORDIC gain from a radius; the product is truncated.
    function automatic longint strip_gain(input longint r);
        longint unsigned u;
        longint unsigned hi;
        longint unsigned lo;
        if (r <= 0)
        begin
            return 0;
        end
        u  = r;
        hi = u >> 31;
        lo = u & 64'h7FFF_FFFF;
        return longint'(hi * RECIP_GAIN + ((lo * RECIP_GAIN) >> 31));
    endfunction

    // Round a 32-bit binary angle half up to the output width; it wraps.
    function automatic vda_pkg::angle_t round_phase(input bit [31:0] p);
        bit [31:0] s;
        s = p + HALF_LSB;
        return vda_pkg::angle_t'(s[31 -: vda_pkg::ANGLE_WIDTH]);
    endfunction

    // Expected angles of one vector in the given mode.
    function automatic vda_pkg::out_t predict_angles(input vda_pkg::in_t v,
                                                     input logic spatial);
        longint        px;
        longint        py;
        longint        pz;
        longint        radius;
        longint        reduced;
        bit [31:0]     azimuth;
        bit [31:0]     elevation;
        vda_pkg::out_t r;
        px = $signed(v.x_coord);
        py = $signed(v.y_coord);
        pz = $signed(v.z_coord);
        px = px <<< SCALE_SHIFT;
        py = py <<< SCALE_SHIFT;
        pz = pz <<< SCALE_SHIFT;
        if (!spatial)
        begin
            elevation      = vector_phase(px, py, radius);
            r.first_angle  = round_phase(elevation);
            r.second_angle = '0;
        end
        else
        begin
            // Turn about Y onto the x axis, then measure the lift of y over the radius.
            azimuth        = vector_phase(px, pz, radius);
            reduced        = strip_gain(radius);
            elevation      = vector_phase(reduced, py, radius);
            r.first_angle  = round_phase(elevation);
            r.second_angle = round_phase(32'd0 - azimuth);
        end
        return r;
    endfunction

    // Track the mode register, queue predictions and check delivered transactions.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spatial_mode <= 1'b1;
            angles_due   <= 0;
            faults       = 0;
            reported     = 0;
            angle_q.delete();
        end
        else
        begin
            // Check the output first so that a result never meets its own input.
            if (out_valid && !out_stall)
            begin
                if (angle_q.size() == 0)
                begin
                    faults = faults + 1;
                    if (reported < 10)
                    begin
                        reported = reported + 1;
                        $display("%0t: unexpected output transaction first=%0d second=%0d",
                                 $realtime, out_data.first_angle, out_data.second_angle);
                    end
                end
                else
                begin
                    head = angle_q.pop_front();
                    if (out_data.first_angle !== head.angles.first_angle ||
                        out_data.second_angle !== head.angles.second_angle)
                    begin
                        faults = faults + 1;
                        if (reported < 10)
                        begin
                            reported = reported + 1;
                            $display({"%0t: mismatch for (%0d, %0d, %0d): ",
                                      "expected %0d %0d, got %0d %0d"},
                                     $realtime, head.vec.x_coord, head.vec.y_coord,
                                     head.vec.z_coord, head.angles.first_angle,
                                     head.angles.second_angle, out_data.first_angle,
                                     out_data.second_angle);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                angle_q.push_back(predicted_t'{vec: in_data,
                                               angles: predict_angles(in_data,
                                                                      spatial_mode)});
            end
            if (cfg_wr_en)
            begin
                spatial_mode <= cfg_wr_data;
            end
            angles_due <= angle_q.size();
        end
    end

endmodule

### bench/tb_top.sv
// Top of the vector direction testbench: clock, reset, vector stimulus and the verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int CMAX = (1 << (vda_pkg::COORD_WIDTH - 1)) - 1;
    localparam int CMIN = -(1 << (vda_pkg::COORD_WIDTH - 1));
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int DRAIN_CYCLES = 60;
    // Mode written at the start of each random phase, phase 0 in bit 0.
    localparam bit [PHASE_COUNT-1:0] MODE_PLAN = 8'b1001_0110;

    logic          clk;
    logic          rst_n;
    logic          cfg_wr_en;
    logic          cfg_wr_data;
    logic          in_valid;
    logic          in_stall;
    vda_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_stall;
    vda_pkg::out_t out_data;
    int            angles_due;
    int            fault_count;
    bit            calm;

    vector_direction_angles dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    direction_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .angles_due  (angles_due),
        .fault_count (fault_count)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run length.
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic vda_pkg::in_t make_vec(input int x, input int y, input int z);
        vda_pkg::in_t v;
        v.x_coord = vda_pkg::coord_t'(x);
        v.y_coord = vda_pkg::coord_t'(y);
        v.z_coord = vda_pkg::coord_t'(z);
        return v;
    endfunction

    // Mix of full-range, small, near-extreme, zero and mid-size coordinates.
    function automatic vda_pkg::coord_t random_coord();
        bit [31:0]       r;
        vda_pkg::coord_t c;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = vda_pkg::coord_t'(r);
            4:          c = vda_pkg::coord_t'(int'($urandom_range(0, 16)) - 8);
            5:          c = vda_pkg::coord_t'(CMAX - int'($urandom_range(0, 3)));
            6:          c = vda_pkg::coord_t'(CMIN + int'($urandom_range(0, 3)));
            7:          c = '0;
            default:    c = {{(vda_pkg::COORD_WIDTH - 12){r[11]}}, r[11:0]};
        endcase
        return c;
    endfunction

    // Offer one vector, with an occasional idle burst first, and wait for acceptance.
    task automatic push_vector(input vda_pkg::in_t v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Let the pipeline empty, then write the mode register.
    task automatic write_mode(input logic mode);
        in_valid <= 1'b0;
        do @(posedge clk); while (angles_due != 0);
        cfg_wr_data <= mode;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Field extremes, the zero vector, the axes and angles close to plus and minus pi.
    task automatic run_directed();
        push_vector(make_vec(0, 0, 0));
        push_vector(make_vec(-1000, 0, 0));
        push_vector(make_vec(CMAX, 0, 0));
        push_vector(make_vec(CMIN, 0, 0));
        push_vector(make_vec(0, CMAX, 0));
        push_vector(make_vec(0, CMIN, 0));
        push_vector(make_vec(0, 0, CMAX));
        push_vector(make_vec(0, 0, CMIN));
        push_vector(make_vec(CMAX, CMAX, CMAX));
        push_vector(make_vec(CMIN, CMIN, CMIN));
        push_vector(make_vec(CMIN, CMAX, CMIN));
        push_vector(make_vec(CMIN, 1, -1));
        push_vector(make_vec(CMIN, -1, 1));
        push_vector(make_vec(-1, -1, CMAX));
    endtask

    // Random output stall bursts between runs without stall.
    initial
    begin
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Reset, directed vectors in both modes, random phases, then drain and verdict.
    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        calm        = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The mode comes out of reset in 3D.
        run_directed();
        write_mode(1'b0);
        run_directed();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_mode(MODE_PLAN[p]);
            if (p == PHASE_COUNT - 1)
            begin
                calm = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                push_vector(vda_pkg::in_t'{x_coord: random_coord(),
                                           y_coord: random_coord(),
                                           z_coord: random_coord()});
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (angles_due != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
